>>> sv/bankers_safety_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Banker's allocator assertion macros
// Shared concurrent assertion forms, clocked on i_clk and gated by reset.
// ----------------------------------------------------------------------------
`ifndef BANKERS_SAFETY_ALLOCATOR_CORE_ASSERT_SVH
`define BANKERS_SAFETY_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("bankers allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("bankers allocator assertion failed");

`endif

>>> sv/bsa_pkg.sv
// ----------------------------------------------------------------------------
// Banker's allocator package
// Sizes, codes, state encoding and row arithmetic for the allocator core.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int PROCESSES   = 5;
    localparam int RESOURCES   = 3;
    localparam int COUNT_WIDTH = 8;

    localparam int FIELD_W   = 24;
    localparam int SEQ_OUT_W = 15;
    localparam int SLOT_W    = 3;
    localparam int ROW_W     = RESOURCES * COUNT_WIDTH;
    localparam int SEQ_W     = SLOT_W * PROCESSES;
    localparam int PIDX_W    = $clog2(PROCESSES);
    localparam int CNT_W     = $clog2(PROCESSES + 1);

    typedef logic [ROW_W-1:0] t_row;

    typedef struct packed {
        t_row alloc;
        t_row need;
    } t_entry;

    typedef enum logic [1:0] {
        FN_LOAD      = 2'd0,
        FN_SET_AVAIL = 2'd1,
        FN_REQUEST   = 2'd2,
        FN_CHECK     = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        STS_OK           = 3'd0,
        STS_EXCEEDS_NEED = 3'd1,
        STS_EXCEEDS_AVL  = 3'd2,
        STS_UNSAFE       = 3'd3,
        STS_LOAD_REJECT  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHK_INIT,
        S_CHECK,
        S_DONE
    } t_state;

    function automatic t_row field_to_row(input logic [FIELD_W-1:0] f);
        logic [ROW_W+FIELD_W-1:0] ext;
        ext = {{ROW_W{1'b0}}, f};
        return ext[ROW_W-1:0];
    endfunction

    function automatic logic [SEQ_OUT_W-1:0] seq_to_out(input logic [SEQ_W-1:0] s);
        logic [SEQ_W+SEQ_OUT_W-1:0] ext;
        ext = {{SEQ_OUT_W{1'b0}}, s};
        return ext[SEQ_OUT_W-1:0];
    endfunction

    function automatic logic row_le(input t_row a, input t_row b);
        logic ok;
        ok = 1'b1;
        for (int j = 0; j < RESOURCES; j++) begin
            if (a[j*COUNT_WIDTH +: COUNT_WIDTH] > b[j*COUNT_WIDTH +: COUNT_WIDTH]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic t_row row_add(input t_row a, input t_row b);
        t_row r;
        r = '0;
        for (int j = 0; j < RESOURCES; j++) begin
            r[j*COUNT_WIDTH +: COUNT_WIDTH] =
                a[j*COUNT_WIDTH +: COUNT_WIDTH] + b[j*COUNT_WIDTH +: COUNT_WIDTH];
        end
        return r;
    endfunction

    function automatic t_row row_sub(input t_row a, input t_row b);
        t_row r;
        r = '0;
        for (int j = 0; j < RESOURCES; j++) begin
            r[j*COUNT_WIDTH +: COUNT_WIDTH] =
                a[j*COUNT_WIDTH +: COUNT_WIDTH] - b[j*COUNT_WIDTH +: COUNT_WIDTH];
        end
        return r;
    endfunction

    function automatic t_row row_sat_add(input t_row a, input t_row b);
        t_row r;
        logic [COUNT_WIDTH:0] s;
        r = '0;
        for (int j = 0; j < RESOURCES; j++) begin
            s = {1'b0, a[j*COUNT_WIDTH +: COUNT_WIDTH]}
              + {1'b0, b[j*COUNT_WIDTH +: COUNT_WIDTH]};
            r[j*COUNT_WIDTH +: COUNT_WIDTH] = s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
                                                             : s[COUNT_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/bankers_safety_allocator_core.sv
// ----------------------------------------------------------------------------
// Banker's safety allocator core
// Keeps allocation and need rows per process in a row memory, loads rows,
// sets the available vector, grants requests that keep the system safe and
// runs the safety check that reports the finishing order.
// ----------------------------------------------------------------------------
// A load or set-available transaction passes through the execute and done
// states after acceptance. A request that passes its need and availability
// checks, or a check transaction, also passes through the check-init state and
// one scan step for every row visited by the safety scan, at most PROCESSES *
// PROCESSES visits; the row memory delivers one process row per cycle to the
// scan. One transaction is worked on at a time, and the next one is accepted
// while the previous result still waits at the output. Rows that were never
// written read as zero through per-row valid bits, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "bankers_safety_allocator_core_assert.svh"

module bankers_safety_allocator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_func,
    input  logic [2:0]                    i_process,
    input  logic [bsa_pkg::FIELD_W-1:0]   i_first_vector,
    input  logic [bsa_pkg::FIELD_W-1:0]   i_second_vector,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_status,
    output logic                          o_granted,
    output logic [bsa_pkg::SEQ_OUT_W-1:0] o_safe_sequence,
    output logic                          o_sequence_valid
);

    bsa_pkg::t_entry                   r_mem [bsa_pkg::PROCESSES];
    logic [bsa_pkg::PROCESSES-1:0]     r_vld;
    bsa_pkg::t_entry                   r_rd_row;
    logic                              r_rd_ok;

    bsa_pkg::t_state                   r_state, n_state;
    bsa_pkg::t_func                    r_func, n_func;
    logic [2:0]                        r_proc, n_proc;
    bsa_pkg::t_row                     r_v1, n_v1;
    bsa_pkg::t_row                     r_v2, n_v2;
    bsa_pkg::t_row                     r_avail, n_avail;
    bsa_pkg::t_row                     r_save_avail, n_save_avail;
    bsa_pkg::t_entry                   r_save, n_save;
    bsa_pkg::t_row                     r_work, n_work;
    logic [bsa_pkg::PROCESSES-1:0]     r_done, n_done;
    logic [bsa_pkg::CNT_W-1:0]         r_count, n_count;
    logic [bsa_pkg::SEQ_W-1:0]         r_order, n_order;
    logic                              r_found, n_found;
    logic [bsa_pkg::PIDX_W-1:0]        r_p, n_p;

    bsa_pkg::t_status                  r_res_status, n_res_status;
    logic                              r_res_granted, n_res_granted;
    logic [bsa_pkg::SEQ_OUT_W-1:0]     r_res_seq, n_res_seq;
    logic                              r_res_sv, n_res_sv;

    logic                              r_out_valid, n_out_valid;
    bsa_pkg::t_status                  r_out_status, n_out_status;
    logic                              r_out_granted, n_out_granted;
    logic [bsa_pkg::SEQ_OUT_W-1:0]     r_out_seq, n_out_seq;
    logic                              r_out_sv, n_out_sv;

    logic                              in_take;
    logic                              we;
    logic [bsa_pkg::PIDX_W-1:0]        waddr;
    bsa_pkg::t_entry                   wdata;
    logic [bsa_pkg::PIDX_W-1:0]        rd_addr;
    bsa_pkg::t_entry                   row;
    logic                              fits;
    logic                              found_now;
    logic [bsa_pkg::CNT_W-1:0]         cnt_next;

    assign o_in_stall       = (r_state != bsa_pkg::S_IDLE);
    assign in_take          = i_in_valid && !o_in_stall;
    assign row              = r_rd_ok ? r_rd_row : '0;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_granted        = r_out_granted;
    assign o_safe_sequence  = r_out_seq;
    assign o_sequence_valid = r_out_sv;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_row <= r_mem[rd_addr];
        r_rd_ok  <= r_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_avail     <= '0;
            r_vld       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_avail     <= n_avail;
            if (we) begin
                r_vld[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func        <= n_func;
        r_proc        <= n_proc;
        r_v1          <= n_v1;
        r_v2          <= n_v2;
        r_save_avail  <= n_save_avail;
        r_save        <= n_save;
        r_work        <= n_work;
        r_done        <= n_done;
        r_count       <= n_count;
        r_order       <= n_order;
        r_found       <= n_found;
        r_p           <= n_p;
        r_res_status  <= n_res_status;
        r_res_granted <= n_res_granted;
        r_res_seq     <= n_res_seq;
        r_res_sv      <= n_res_sv;
        r_out_status  <= n_out_status;
        r_out_granted <= n_out_granted;
        r_out_seq     <= n_out_seq;
        r_out_sv      <= n_out_sv;
    end

    always_comb begin
        n_state       = r_state;
        n_func        = r_func;
        n_proc        = r_proc;
        n_v1          = r_v1;
        n_v2          = r_v2;
        n_avail       = r_avail;
        n_save_avail  = r_save_avail;
        n_save        = r_save;
        n_work        = r_work;
        n_done        = r_done;
        n_count       = r_count;
        n_order       = r_order;
        n_found       = r_found;
        n_p           = r_p;
        n_res_status  = r_res_status;
        n_res_granted = r_res_granted;
        n_res_seq     = r_res_seq;
        n_res_sv      = r_res_sv;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_status  = r_out_status;
        n_out_granted = r_out_granted;
        n_out_seq     = r_out_seq;
        n_out_sv      = r_out_sv;
        we            = 1'b0;
        waddr         = r_proc[bsa_pkg::PIDX_W-1:0];
        wdata         = '0;
        rd_addr       = '0;

        fits      = !r_done[r_p] && bsa_pkg::row_le(row.need, r_work);
        found_now = r_found || fits;
        cnt_next  = fits ? bsa_pkg::CNT_W'(r_count + 1'b1) : r_count;

        case (r_state)
            bsa_pkg::S_IDLE: begin
                rd_addr = i_process[bsa_pkg::PIDX_W-1:0];
                if (in_take) begin
                    n_func  = bsa_pkg::t_func'(i_func);
                    n_proc  = i_process;
                    n_v1    = bsa_pkg::field_to_row(i_first_vector);
                    n_v2    = bsa_pkg::field_to_row(i_second_vector);
                    n_state = bsa_pkg::S_EXEC;
                end
            end

            bsa_pkg::S_EXEC: begin
                n_res_status  = bsa_pkg::STS_OK;
                n_res_granted = 1'b0;
                n_res_seq     = '0;
                n_res_sv      = 1'b0;
                n_state       = bsa_pkg::S_DONE;
                case (r_func)
                    bsa_pkg::FN_LOAD: begin
                        if (int'(r_proc) >= bsa_pkg::PROCESSES ||
                            !bsa_pkg::row_le(r_v1, r_v2)) begin
                            n_res_status = bsa_pkg::STS_LOAD_REJECT;
                        end else begin
                            we          = 1'b1;
                            wdata.alloc = r_v1;
                            wdata.need  = bsa_pkg::row_sub(r_v2, r_v1);
                        end
                    end
                    bsa_pkg::FN_SET_AVAIL: begin
                        n_avail = r_v1;
                    end
                    bsa_pkg::FN_REQUEST: begin
                        if (int'(r_proc) >= bsa_pkg::PROCESSES ||
                            !bsa_pkg::row_le(r_v1, row.need)) begin
                            n_res_status = bsa_pkg::STS_EXCEEDS_NEED;
                        end else if (!bsa_pkg::row_le(r_v1, r_avail)) begin
                            n_res_status = bsa_pkg::STS_EXCEEDS_AVL;
                        end else begin
                            we           = 1'b1;
                            wdata.alloc  = bsa_pkg::row_add(row.alloc, r_v1);
                            wdata.need   = bsa_pkg::row_sub(row.need, r_v1);
                            n_save       = row;
                            n_save_avail = r_avail;
                            n_avail      = bsa_pkg::row_sub(r_avail, r_v1);
                            n_state      = bsa_pkg::S_CHK_INIT;
                        end
                    end
                    bsa_pkg::FN_CHECK: begin
                        n_state = bsa_pkg::S_CHK_INIT;
                    end
                    default: begin
                        n_state = bsa_pkg::S_DONE;
                    end
                endcase
            end

            bsa_pkg::S_CHK_INIT: begin
                rd_addr = '0;
                n_work  = r_avail;
                n_done  = '0;
                n_count = '0;
                n_order = '0;
                n_found = 1'b0;
                n_p     = '0;
                n_state = bsa_pkg::S_CHECK;
            end

            bsa_pkg::S_CHECK: begin
                if (fits) begin
                    n_work        = bsa_pkg::row_sat_add(r_work, row.alloc);
                    n_done[r_p]   = 1'b1;
                    for (int k = 0; k < bsa_pkg::PROCESSES; k++) begin
                        if (k == int'(r_count)) begin
                            n_order[k*bsa_pkg::SLOT_W +: bsa_pkg::SLOT_W] =
                                bsa_pkg::SLOT_W'(r_p);
                        end
                    end
                end
                n_count = cnt_next;
                n_found = found_now;
                if (cnt_next == bsa_pkg::CNT_W'(bsa_pkg::PROCESSES)) begin
                    n_res_status  = bsa_pkg::STS_OK;
                    n_res_granted = (r_func == bsa_pkg::FN_REQUEST);
                    n_res_seq     = bsa_pkg::seq_to_out(n_order);
                    n_res_sv      = 1'b1;
                    n_state       = bsa_pkg::S_DONE;
                end else if (r_p == bsa_pkg::PIDX_W'(bsa_pkg::PROCESSES - 1)) begin
                    if (!found_now) begin
                        n_res_status  = bsa_pkg::STS_UNSAFE;
                        n_res_granted = 1'b0;
                        n_res_seq     = '0;
                        n_res_sv      = 1'b0;
                        n_state       = bsa_pkg::S_DONE;
                        if (r_func == bsa_pkg::FN_REQUEST) begin
                            we      = 1'b1;
                            wdata   = r_save;
                            n_avail = r_save_avail;
                        end
                    end else begin
                        n_p     = '0;
                        n_found = 1'b0;
                        rd_addr = '0;
                    end
                end else begin
                    n_p     = bsa_pkg::PIDX_W'(r_p + 1'b1);
                    rd_addr = bsa_pkg::PIDX_W'(r_p + 1'b1);
                end
            end

            bsa_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_granted = r_res_granted;
                    n_out_seq     = r_res_seq;
                    n_out_sv      = r_res_sv;
                    n_state       = bsa_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bsa_pkg::S_IDLE;
            end
        endcase
    end

    `BSA_ASSERT_SAME(a_granted_is_safe, r_out_valid && r_out_granted, r_out_sv && (r_out_status == bsa_pkg::STS_OK))
    `BSA_ASSERT_SAME(a_seq_zero_when_invalid, r_out_valid && !r_out_sv, r_out_seq == '0)
    `BSA_ASSERT_SAME(a_done_matches_count, r_state == bsa_pkg::S_CHECK, $countones(r_done) == int'(r_count))
    `BSA_ASSERT_NEXT(a_take_leaves_idle, in_take, r_state == bsa_pkg::S_EXEC)

endmodule

>>> tb/sv/bankers_safety_allocator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Banker's safety allocator core testbench
// A short table of directed transactions opens the run. It covers reset state,
// load rejects, out of range processes, full-scale counts, work-vector
// saturation and a classic five-process example with grants, need and
// availability errors, an unsafe request and an all-zero request. Random
// transactions follow, most well formed and some pure noise. Each result is
// checked against its row's fixed expectation or a predictor that keeps its
// own copy of the allocation, need and available state. Both channels idle at
// random, and once the result side stalls long enough to back the input up.
// ----------------------------------------------------------------------------
module bankers_safety_allocator_core_tb;

    localparam int RANDOM_ITEMS  = 2000;
    localparam int DIRECTED_ROWS = 25;
    localparam int MAX_GAP       = 17;
    localparam int PRESSURE_AT   = 500;
    localparam int PRESSURE_HOLD = 400;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 3000;
    localparam int CW            = bsa_pkg::COUNT_WIDTH;

    typedef struct packed {
        bsa_pkg::t_status               status;
        logic                           granted;
        logic [bsa_pkg::SEQ_OUT_W-1:0]  seq;
        logic                           seq_valid;
    } t_outcome;

    typedef struct {
        bsa_pkg::t_func                 fn;
        logic [2:0]                     pid;
        logic [bsa_pkg::FIELD_W-1:0]    v1;
        logic [bsa_pkg::FIELD_W-1:0]    v2;
        bit                             fixed;
        t_outcome                       expected;
    } t_stim_row;

    localparam t_outcome PLAIN_OK    = '{bsa_pkg::STS_OK, 1'b0, '0, 1'b0};
    localparam t_outcome LOAD_REJECT = '{bsa_pkg::STS_LOAD_REJECT, 1'b0, '0, 1'b0};
    localparam t_outcome NEED_ERROR  = '{bsa_pkg::STS_EXCEEDS_NEED, 1'b0, '0, 1'b0};
    localparam t_outcome RESET_CHECK = '{bsa_pkg::STS_OK, 1'b0, 15'h4688, 1'b1};

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{bsa_pkg::FN_CHECK,     3'd0, 24'h000000, 24'h000000, 1'b1, RESET_CHECK},
        '{bsa_pkg::FN_LOAD,      3'd5, 24'h000000, 24'h000000, 1'b1, LOAD_REJECT},
        '{bsa_pkg::FN_LOAD,      3'd7, 24'h000000, 24'hFFFFFF, 1'b1, LOAD_REJECT},
        '{bsa_pkg::FN_LOAD,      3'd0, 24'h010000, 24'h00FFFF, 1'b1, LOAD_REJECT},
        '{bsa_pkg::FN_REQUEST,   3'd6, 24'h000000, 24'h000000, 1'b1, NEED_ERROR},
        '{bsa_pkg::FN_LOAD,      3'd0, 24'h000000, 24'hFFFFFF, 1'b1, PLAIN_OK},
        '{bsa_pkg::FN_SET_AVAIL, 3'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, PLAIN_OK},
        '{bsa_pkg::FN_REQUEST,   3'd0, 24'hFFFFFF, 24'h000000, 1'b0, PLAIN_OK},
        '{bsa_pkg::FN_LOAD,      3'd1, 24'hFFFFFF, 24'hFFFFFF, 1'b1, PLAIN_OK},
        '{bsa_pkg::FN_CHECK,     3'd7, 24'hFFFFFF, 24'hFFFFFF, 1'b0, PLAIN_OK},
        '{bsa_pkg::FN_LOAD,      3'd0, 24'h000100, 24'h030507, 1'b1, PLAIN_OK},
        '{bsa_pkg::FN_LOAD,      3'd1, 24'h000002, 24'h020203, 1'b1, PLAIN_OK},
        '{bsa_pkg::FN_LOAD,      3'd2, 24'h020003, 24'h020009, 1'b1, PLAIN_OK},
        '{bsa_pkg::FN_LOAD,      3'd3, 24'h010102, 24'h020202, 1'b1, PLAIN_OK},
        '{bsa_pkg::FN_LOAD,      3'd4, 24'h020000, 24'h030304, 1'b1, PLAIN_OK},
        '{bsa_pkg::FN_SET_AVAIL, 3'd0, 24'h020303, 24'h000000, 1'b1, PLAIN_OK},
        '{bsa_pkg::FN_CHECK,     3'd0, 24'h000000, 24'h000000, 1'b0, PLAIN_OK},
        '{bsa_pkg::FN_REQUEST,   3'd1, 24'h020001, 24'h000000, 1'b0, PLAIN_OK},
        '{bsa_pkg::FN_REQUEST,   3'd4, 24'h030303, 24'h000000, 1'b0, PLAIN_OK},
        '{bsa_pkg::FN_REQUEST,   3'd0, 24'h000400, 24'h000000, 1'b0, PLAIN_OK},
        '{bsa_pkg::FN_REQUEST,   3'd0, 24'h000200, 24'h000000, 1'b0, PLAIN_OK},
        '{bsa_pkg::FN_REQUEST,   3'd3, 24'h000000, 24'h000000, 1'b0, PLAIN_OK},
        '{bsa_pkg::FN_SET_AVAIL, 3'd0, 24'h000000, 24'h000000, 1'b1, PLAIN_OK},
        '{bsa_pkg::FN_CHECK,     3'd0, 24'h000000, 24'h000000, 1'b0, PLAIN_OK},
        '{bsa_pkg::FN_LOAD,      3'd4, 24'hFFFFFF, 24'h000000, 1'b1, LOAD_REJECT}
    };

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic [1:0]                     i_func = bsa_pkg::FN_LOAD;
    logic [2:0]                     i_process = 3'd0;
    logic [bsa_pkg::FIELD_W-1:0]    i_first_vector = '0;
    logic [bsa_pkg::FIELD_W-1:0]    i_second_vector = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [2:0]                     o_status;
    logic                           o_granted;
    logic [bsa_pkg::SEQ_OUT_W-1:0]  o_safe_sequence;
    logic                           o_sequence_valid;

    bsa_pkg::t_row  model_alloc [bsa_pkg::PROCESSES];
    bsa_pkg::t_row  model_need [bsa_pkg::PROCESSES];
    bsa_pkg::t_row  model_avail;
    t_outcome       pending_outcomes [$];
    int             error_count = 0;
    int             sent_count = 0;
    int             results_taken = 0;
    int             grant_count = 0;
    int             unsafe_count = 0;
    int             reject_count = 0;

    bankers_safety_allocator_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_process        (i_process),
        .i_first_vector   (i_first_vector),
        .i_second_vector  (i_second_vector),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_granted        (o_granted),
        .o_safe_sequence  (o_safe_sequence),
        .o_sequence_valid (o_sequence_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic scan_safe_order(output logic [bsa_pkg::SEQ_OUT_W-1:0] order);
        bsa_pkg::t_row                  work;
        logic [bsa_pkg::PROCESSES-1:0]  done;
        int                             finished;
        logic                           progress;
        logic                           fits;
        logic [CW:0]                    total;
        work = model_avail;
        done = '0;
        finished = 0;
        order = '0;
        while (finished < bsa_pkg::PROCESSES) begin
            progress = 1'b0;
            for (int p = 0; p < bsa_pkg::PROCESSES; p++) begin
                if (!done[p]) begin
                    fits = 1'b1;
                    for (int j = 0; j < bsa_pkg::RESOURCES; j++) begin
                        if (model_need[p][j*CW +: CW] > work[j*CW +: CW]) begin
                            fits = 1'b0;
                        end
                    end
                    if (fits) begin
                        for (int j = 0; j < bsa_pkg::RESOURCES; j++) begin
                            total = {1'b0, work[j*CW +: CW]}
                                  + {1'b0, model_alloc[p][j*CW +: CW]};
                            work[j*CW +: CW] = total[CW] ? {CW{1'b1}} : total[CW-1:0];
                        end
                        order[finished*bsa_pkg::SLOT_W +: bsa_pkg::SLOT_W] =
                            bsa_pkg::SLOT_W'(p);
                        finished++;
                        done[p] = 1'b1;
                        progress = 1'b1;
                    end
                end
            end
            if (!progress) begin
                order = '0;
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_outcome predict_outcome(bsa_pkg::t_func fn, logic [2:0] pid,
                                                 bsa_pkg::t_row v1, bsa_pkg::t_row v2);
        t_outcome                       res;
        logic                           bad;
        bsa_pkg::t_row                  need_row;
        bsa_pkg::t_row                  save_alloc;
        bsa_pkg::t_row                  save_need;
        bsa_pkg::t_row                  save_avail;
        logic [CW-1:0]                  amount;
        logic [bsa_pkg::SEQ_OUT_W-1:0]  order;
        res = PLAIN_OK;
        case (fn)
            bsa_pkg::FN_LOAD: begin
                bad = 1'b0;
                need_row = '0;
                for (int j = 0; j < bsa_pkg::RESOURCES; j++) begin
                    if (v1[j*CW +: CW] > v2[j*CW +: CW]) begin
                        bad = 1'b1;
                    end
                    need_row[j*CW +: CW] = v2[j*CW +: CW] - v1[j*CW +: CW];
                end
                if (pid >= bsa_pkg::PROCESSES || bad) begin
                    res.status = bsa_pkg::STS_LOAD_REJECT;
                end else begin
                    model_alloc[pid] = v1;
                    model_need[pid] = need_row;
                end
            end
            bsa_pkg::FN_SET_AVAIL: begin
                model_avail = v1;
            end
            bsa_pkg::FN_REQUEST: begin
                if (pid >= bsa_pkg::PROCESSES) begin
                    res.status = bsa_pkg::STS_EXCEEDS_NEED;
                end else begin
                    for (int j = 0; j < bsa_pkg::RESOURCES; j++) begin
                        if (v1[j*CW +: CW] > model_need[pid][j*CW +: CW]) begin
                            res.status = bsa_pkg::STS_EXCEEDS_NEED;
                        end
                    end
                    if (res.status == bsa_pkg::STS_OK) begin
                        for (int j = 0; j < bsa_pkg::RESOURCES; j++) begin
                            if (v1[j*CW +: CW] > model_avail[j*CW +: CW]) begin
                                res.status = bsa_pkg::STS_EXCEEDS_AVL;
                            end
                        end
                    end
                    if (res.status == bsa_pkg::STS_OK) begin
                        save_alloc = model_alloc[pid];
                        save_need = model_need[pid];
                        save_avail = model_avail;
                        for (int j = 0; j < bsa_pkg::RESOURCES; j++) begin
                            amount = v1[j*CW +: CW];
                            model_avail[j*CW +: CW] -= amount;
                            model_alloc[pid][j*CW +: CW] += amount;
                            model_need[pid][j*CW +: CW] -= amount;
                        end
                        if (scan_safe_order(order)) begin
                            res.granted = 1'b1;
                            res.seq_valid = 1'b1;
                            res.seq = order;
                        end else begin
                            model_alloc[pid] = save_alloc;
                            model_need[pid] = save_need;
                            model_avail = save_avail;
                            res.status = bsa_pkg::STS_UNSAFE;
                        end
                    end
                end
            end
            default: begin
                if (scan_safe_order(order)) begin
                    res.seq_valid = 1'b1;
                    res.seq = order;
                end else begin
                    res.status = bsa_pkg::STS_UNSAFE;
                end
            end
        endcase
        return res;
    endfunction

    task automatic draw_transaction(output bsa_pkg::t_func fn, output logic [2:0] pid,
                                    output logic [bsa_pkg::FIELD_W-1:0] v1,
                                    output logic [bsa_pkg::FIELD_W-1:0] v2);
        int             kind;
        logic [CW-1:0]  held;
        logic [CW-1:0]  claim;
        logic [CW-1:0]  limit;
        kind = $urandom_range(0, 99);
        pid = 3'($urandom_range(0, bsa_pkg::PROCESSES - 1));
        if ($urandom_range(0, 24) == 0) begin
            pid = 3'($urandom_range(bsa_pkg::PROCESSES, 7));
        end
        v1 = bsa_pkg::FIELD_W'($urandom());
        v2 = bsa_pkg::FIELD_W'($urandom());
        if (kind < 20) begin
            fn = bsa_pkg::FN_LOAD;
            if ($urandom_range(0, 9) == 0) begin
                v2 = {bsa_pkg::FIELD_W{1'b1}};
            end else begin
                for (int j = 0; j < bsa_pkg::RESOURCES; j++) begin
                    held = CW'($urandom_range(0, 6));
                    claim = held + CW'($urandom_range(0, 6));
                    if ($urandom_range(0, 19) == 0 && held > 0) begin
                        claim = held - 1'b1;
                    end
                    v1[j*CW +: CW] = held;
                    v2[j*CW +: CW] = claim;
                end
            end
        end else if (kind < 35) begin
            fn = bsa_pkg::FN_SET_AVAIL;
            if ($urandom_range(0, 9) != 0) begin
                for (int j = 0; j < bsa_pkg::RESOURCES; j++) begin
                    v1[j*CW +: CW] = CW'($urandom_range(0, 15));
                end
            end
        end else if (kind < 70) begin
            fn = bsa_pkg::FN_REQUEST;
            if (pid < bsa_pkg::PROCESSES) begin
                for (int j = 0; j < bsa_pkg::RESOURCES; j++) begin
                    limit = model_need[pid][j*CW +: CW];
                    v1[j*CW +: CW] = CW'($urandom_range(0, limit));
                    if ($urandom_range(0, 7) == 0) begin
                        v1[j*CW +: CW] = limit + 1'b1;
                    end
                end
            end
        end else if (kind < 85) begin
            fn = bsa_pkg::FN_CHECK;
        end else begin
            fn = bsa_pkg::t_func'($urandom_range(0, 3));
            pid = 3'($urandom_range(0, 7));
        end
    endtask

    task automatic offer_transaction(bsa_pkg::t_func fn, logic [2:0] pid,
                                     logic [bsa_pkg::FIELD_W-1:0] v1,
                                     logic [bsa_pkg::FIELD_W-1:0] v2);
        int gap;
        gap = ((sent_count / 150) % 4 == 2) ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= fn;
        i_process <= pid;
        i_first_vector <= v1;
        i_second_vector <= v2;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sent_count++;
    endtask

    task automatic record_outcome(t_outcome res);
        pending_outcomes.push_back(res);
        if (res.granted) grant_count++;
        if (res.status == bsa_pkg::STS_UNSAFE) unsafe_count++;
        if (res.status == bsa_pkg::STS_LOAD_REJECT ||
            res.status == bsa_pkg::STS_EXCEEDS_NEED) reject_count++;
    endtask

    task automatic compare_outcome();
        t_outcome exp;
        if (pending_outcomes.size() == 0) begin
            $error("result transaction arrived with no expectation pending");
            error_count++;
        end else begin
            exp = pending_outcomes.pop_front();
            if (o_status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, o_status);
                error_count++;
            end
            if (o_granted !== exp.granted) begin
                $error("granted: expected %0d, actual %0d", exp.granted, o_granted);
                error_count++;
            end
            if (o_safe_sequence !== exp.seq) begin
                $error("safe_sequence: expected %h, actual %h", exp.seq, o_safe_sequence);
                error_count++;
            end
            if (o_sequence_valid !== exp.seq_valid) begin
                $error("sequence_valid: expected %0d, actual %0d",
                       exp.seq_valid, o_sequence_valid);
                error_count++;
            end
        end
    endtask

    initial begin
        int hold;
        wait (i_rst_n === 1'b1);
        forever begin
            if (results_taken == PRESSURE_AT) begin
                hold = PRESSURE_HOLD;
            end else if ((results_taken / 130) % 4 == 1) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, MAX_GAP);
            end
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            compare_outcome();
            results_taken++;
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Watchdog expired with %0d results outstanding.", pending_outcomes.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        bsa_pkg::t_func                 fn;
        logic [2:0]                     pid;
        logic [bsa_pkg::FIELD_W-1:0]    v1;
        logic [bsa_pkg::FIELD_W-1:0]    v2;
        t_outcome                       res;
        for (int p = 0; p < bsa_pkg::PROCESSES; p++) begin
            model_alloc[p] = '0;
            model_need[p] = '0;
        end
        model_avail = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            offer_transaction(directed_rows[k].fn, directed_rows[k].pid,
                              directed_rows[k].v1, directed_rows[k].v2);
            res = predict_outcome(directed_rows[k].fn, directed_rows[k].pid,
                                  directed_rows[k].v1, directed_rows[k].v2);
            record_outcome(directed_rows[k].fixed ? directed_rows[k].expected : res);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            draw_transaction(fn, pid, v1, v2);
            offer_transaction(fn, pid, v1, v2);
            record_outcome(predict_outcome(fn, pid, v1, v2));
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending_outcomes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d transactions (%0d directed) and checked %0d results.",
                 sent_count, DIRECTED_ROWS, results_taken);
        $display("Grants %0d, unsafe %0d, rejected %0d, mismatches %0d.",
                 grant_count, unsafe_count, reject_count, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
